// ===== rtl/cnlc_pkg.sv =====
package cnlc_pkg;

    // parameter defaults and limits
    localparam int MAX_DIGITS_DEF = 19;
    localparam int MIN_DIGITS     = 13;

    // character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // network classes
    typedef enum logic [2:0] {
        NET_UNKNOWN  = 3'd0,
        NET_CLASS_V  = 3'd1,
        NET_CLASS_M  = 3'd2,
        NET_CLASS_A  = 3'd3,
        NET_CLASS_J  = 3'd4,
        NET_CLASS_U  = 3'd5,
        NET_CLASS_DC = 3'd6,
        NET_CLASS_DS = 3'd7
    } t_net;

    // one character of the entry
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_entry;
    } t_item;

    // one result per entry
    typedef struct packed {
        logic       format_ok;
        logic       checksum_ok;
        t_net       network_class;
        logic [4:0] digit_total;
    } t_result;

    // ordered prefix and length tests
    function automatic t_net classify(input logic [6:0] p2, input logic [13:0] p4,
                                      input logic [4:0] n);
        t_net cls;
        cls = NET_UNKNOWN;
        if (p2 >= 7'd40 && p2 <= 7'd49 && (n == 5'd13 || n == 5'd16)) begin
            cls = NET_CLASS_V;
        end else if (((p2 >= 7'd51 && p2 <= 7'd55) || (p4 >= 14'd2221 && p4 <= 14'd2720))
                     && n == 5'd16) begin
            cls = NET_CLASS_M;
        end else if ((p2 == 7'd34 || p2 == 7'd37 || p2 == 7'd30) && n == 5'd15) begin
            cls = NET_CLASS_A;
        end else if (p2 == 7'd35 && n == 5'd16) begin
            cls = NET_CLASS_J;
        end else if (p2 == 7'd62 && n >= 5'd16 && n <= 5'd19) begin
            cls = NET_CLASS_U;
        end else if ((p2 == 7'd30 || p2 == 7'd36 || p2 == 7'd38 || p2 == 7'd39)
                     && n == 5'd14) begin
            cls = NET_CLASS_DC;
        end else if (p2 >= 7'd60 && p2 <= 7'd69 && n == 5'd16) begin
            cls = NET_CLASS_DS;
        end
        return cls;
    endfunction

endpackage

// ===== rtl/card_number_luhn_checker.sv =====
// the last character of an entry passes the input register, then the output register, to give its result
// throughput: one character per cycle, set by the single update stage of the running sums
// while a result waits to be taken, characters keep flowing and only the next end mark stalls
// reset (synchronous, active low) empties both registers and clears all running state
module card_number_luhn_checker
    import cnlc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_in_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_result
);

    localparam int DIGIT_CAP = ((MAX_DIGITS + 1) > 31) ? 31 : (MAX_DIGITS + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eoe;

    // running state
    logic [4:0] r_count;
    logic [3:0] r_sum_even;
    logic [3:0] r_sum_odd;
    logic [3:0] r_lead [4];
    logic       r_bad;

    // output register
    logic    r_out_valid;
    t_result r_out;

    logic       in_xfer;
    logic       out_free;
    logic       advance;
    logic       is_sep;
    logic       is_digit;
    logic [7:0] diff;
    logic [3:0] dgt;
    logic [4:0] dbl_raw;
    logic [3:0] dbl;
    logic [4:0] add_e;
    logic [4:0] add_o;
    logic [3:0] n_sum_even;
    logic [3:0] n_sum_odd;
    logic [4:0] n_count;
    logic       n_bad;
    logic [3:0] lead_now [4];
    logic [6:0] p2;
    logic [13:0] p4;
    logic       fmt;
    logic [3:0] sum_pick;
    t_result    n_out;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_eoe || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // character decode and digit doubling
    always_comb begin
        is_sep   = (r_char == CHAR_SPACE) || (r_char == CHAR_DASH);
        is_digit = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);
        diff     = r_char - CHAR_ZERO;
        dgt      = diff[3:0];
        dbl_raw  = {dgt, 1'b0};
        dbl      = (dbl_raw >= 5'd10) ? 4'(dbl_raw - 5'd9) : dbl_raw[3:0];
    end

    // next running sums, count and bad flag
    always_comb begin
        add_e = r_count[0] ? 5'(r_sum_even) + 5'(dgt) : 5'(r_sum_even) + 5'(dbl);
        add_o = r_count[0] ? 5'(r_sum_odd) + 5'(dbl) : 5'(r_sum_odd) + 5'(dgt);
        if (is_digit) begin
            n_sum_even = (add_e >= 5'd10) ? 4'(add_e - 5'd10) : add_e[3:0];
            n_sum_odd  = (add_o >= 5'd10) ? 4'(add_o - 5'd10) : add_o[3:0];
            n_count    = (r_count < 5'(DIGIT_CAP)) ? r_count + 5'd1 : r_count;
        end else begin
            n_sum_even = r_sum_even;
            n_sum_odd  = r_sum_odd;
            n_count    = r_count;
        end
        n_bad = r_bad || (!is_sep && !is_digit);
        for (int k = 0; k < 4; k++) begin
            lead_now[k] = r_lead[k];
        end
        if (is_digit && r_count < 5'd4) begin
            lead_now[r_count[1:0]] = dgt;
        end
    end

    // result of an entry ending on this character
    always_comb begin
        p2       = 7'(lead_now[0]) * 7'd10 + 7'(lead_now[1]);
        p4       = 14'(p2) * 14'd100 + 14'(lead_now[2]) * 14'd10 + 14'(lead_now[3]);
        fmt      = !n_bad && (n_count >= 5'(MIN_DIGITS)) && (n_count <= 5'(MAX_DIGITS));
        sum_pick = n_count[0] ? n_sum_odd : n_sum_even;
        n_out.format_ok     = fmt;
        n_out.checksum_ok   = fmt && (sum_pick == 4'd0);
        n_out.network_class = fmt ? classify(p2, p4, n_count) : NET_UNKNOWN;
        n_out.digit_total   = n_count;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_char <= i_in_item.char_code;
            r_eoe  <= i_in_item.end_of_entry;
        end
    end

    // running state, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum_even <= '0;
            r_sum_odd  <= '0;
            r_bad      <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_lead[k] <= '0;
            end
        end else if (advance) begin
            if (r_eoe) begin
                r_count    <= '0;
                r_sum_even <= '0;
                r_sum_odd  <= '0;
                r_bad      <= 1'b0;
                for (int k = 0; k < 4; k++) begin
                    r_lead[k] <= '0;
                end
            end else begin
                r_count    <= n_count;
                r_sum_even <= n_sum_even;
                r_sum_odd  <= n_sum_odd;
                r_bad      <= n_bad;
                for (int k = 0; k < 4; k++) begin
                    r_lead[k] <= lead_now[k];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_eoe) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_eoe) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

endmodule

// ===== rtl/cnlc_checker.sv =====
module cnlc_checker
    import cnlc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_ready,
    input t_item   i_in_item,
    input logic    o_out_valid,
    input logic    i_out_ready,
    input t_result o_out_result
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_result))
        else $error("result changed or dropped while stalled");

    // a badly formed entry carries no checksum and no class
    a_bad_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_result.format_ok |->
            !o_out_result.checksum_ok && o_out_result.network_class == NET_UNKNOWN)
        else $error("fields set on a badly formed entry");

    // a well formed entry has a legal digit count
    a_fmt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_result.format_ok |->
            o_out_result.digit_total >= 5'(MIN_DIGITS)
            && o_out_result.digit_total <= 5'(MAX_DIGITS))
        else $error("format ok with illegal digit count");

    // a fresh result follows the transfer of an end mark through the input and output registers
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && i_in_item.end_of_entry, 2))
        else $error("result without a prior end mark");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind card_number_luhn_checker cnlc_checker #(.MAX_DIGITS(MAX_DIGITS)) u_cnlc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_in_item    (i_in_item),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_result (o_out_result)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cnlc_pkg::*;

    localparam int DIGIT_CAP   = (MAX_DIGITS_DEF + 1 > 31) ? 31 : MAX_DIGITS_DEF + 1;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_item   in_item = '0;
    logic    out_valid;
    logic    out_ready = 1'b1;
    t_result out_result;

    // luhn predictor state
    int tally;
    int sum_even_dbl;
    int sum_odd_dbl;
    int lead_value;
    bit saw_bad;

    t_result expected_results[$];
    int      mismatches;
    int      results_checked;
    int      chars_sent;
    int      entries_closed;
    int      class_hits[8];
    int      cycle_count;
    bit      quiet;
    bit      calm;
    bit      hold_pending;

    card_number_luhn_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_result(out_result)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d results outstanding", $time,
                     expected_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ordered prefix and length tests
    function automatic t_net card_network(input int lead, input int n);
        int p2;
        p2 = lead / 100;
        if (p2 >= 40 && p2 <= 49 && (n == 13 || n == 16)) return NET_CLASS_V;
        if (n == 16 && ((p2 >= 51 && p2 <= 55) || (lead >= 2221 && lead <= 2720)))
            return NET_CLASS_M;
        if (n == 15 && (p2 == 34 || p2 == 37 || p2 == 30)) return NET_CLASS_A;
        if (n == 16 && p2 == 35) return NET_CLASS_J;
        if (p2 == 62 && n >= 16 && n <= 19) return NET_CLASS_U;
        if (n == 14 && (p2 == 30 || p2 == 36 || p2 == 38 || p2 == 39)) return NET_CLASS_DC;
        if (n == 16 && p2 >= 60 && p2 <= 69) return NET_CLASS_DS;
        return NET_UNKNOWN;
    endfunction

    // fold one accepted character into the running sums, queue a result on the end mark
    task automatic luhn_predict(input t_item it);
        int      d;
        int      dbl;
        int      pick;
        bit      fmt;
        t_result r;
        if (it.char_code == CHAR_SPACE || it.char_code == CHAR_DASH) begin
            // separator, skipped
        end else if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE) begin
            d = int'(it.char_code - CHAR_ZERO);
            dbl = 2 * d;
            if (dbl > 9) dbl -= 9;
            if (tally < 4) lead_value = lead_value * 10 + d;
            if (tally % 2 == 0) begin
                sum_even_dbl = (sum_even_dbl + dbl) % 10;
                sum_odd_dbl  = (sum_odd_dbl + d) % 10;
            end else begin
                sum_even_dbl = (sum_even_dbl + d) % 10;
                sum_odd_dbl  = (sum_odd_dbl + dbl) % 10;
            end
            if (tally < DIGIT_CAP) tally++;
        end else begin
            saw_bad = 1'b1;
        end
        if (it.end_of_entry) begin
            fmt = !saw_bad && tally >= MIN_DIGITS && tally <= MAX_DIGITS_DEF;
            r.format_ok     = fmt;
            r.checksum_ok   = 1'b0;
            r.network_class = NET_UNKNOWN;
            r.digit_total   = 5'(tally);
            if (fmt) begin
                // even count: leftmost digit is the doubled one
                pick = (tally % 2 == 0) ? sum_even_dbl : sum_odd_dbl;
                r.checksum_ok   = (pick == 0);
                r.network_class = card_network(lead_value, tally);
            end
            expected_results.push_back(r);
            entries_closed++;
            tally        = 0;
            sum_even_dbl = 0;
            sum_odd_dbl  = 0;
            lead_value   = 0;
            saw_bad      = 1'b0;
        end
    endtask

    // result checker
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, out_result);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (out_result.format_ok !== want.format_ok) begin
                    $display("%0t: format_ok expected %0b got %0b", $time,
                             want.format_ok, out_result.format_ok);
                    mismatches++;
                end
                if (out_result.checksum_ok !== want.checksum_ok) begin
                    $display("%0t: checksum_ok expected %0b got %0b", $time,
                             want.checksum_ok, out_result.checksum_ok);
                    mismatches++;
                end
                if (out_result.network_class !== want.network_class) begin
                    $display("%0t: network_class expected %0d got %0d", $time,
                             want.network_class, out_result.network_class);
                    mismatches++;
                end
                if (out_result.digit_total !== want.digit_total) begin
                    $display("%0t: digit_total expected %0d got %0d", $time,
                             want.digit_total, out_result.digit_total);
                    mismatches++;
                end
                class_hits[want.network_class]++;
            end
        end
    end

    // result side ready, random stall bursts and one long hold-off on request
    initial begin
        int burst;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                for (int k = 0; k < LONG_HOLD; k++) @(posedge clk);
                out_ready <= 1'b1;
            end else if (rst_n && !quiet && !calm && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // one character transfer, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] code, input logic last);
        int    gap;
        t_item it;
        if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.char_code    = code;
        it.end_of_entry = last;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        luhn_predict(it);
        chars_sent++;
    endtask

    // digit string from the left, with optional separators and a trailing end mark
    task automatic send_digits(input int digs[$], input bit with_end);
        bit tail_sep;
        tail_sep = with_end && $urandom_range(0, 9) == 0;
        for (int i = 0; i < digs.size(); i++) begin
            if (i > 0 && $urandom_range(0, 9) == 0)
                send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_DASH, 1'b0);
            send_char(CHAR_ZERO + 8'(digs[i]), with_end && !tail_sep && i == digs.size() - 1);
        end
        if (tail_sep || (with_end && digs.size() == 0))
            send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_DASH, 1'b1);
    endtask

    // random entry: mostly card-like (network prefix, length, often a correct check digit), else digits or bytes
    task automatic send_random_entry();
        int digs[$];
        int kind;
        int n;
        int p;
        int s;
        int v;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            case ($urandom_range(0, 7))
                0: begin p = $urandom_range(10, 99);   n = $urandom_range(12, 20); end
                1: begin p = $urandom_range(40, 49);   n = $urandom_range(0, 1) ? 13 : 16; end
                2: begin
                    p = $urandom_range(0, 1) ? $urandom_range(51, 55)
                                             : $urandom_range(2221, 2720);
                    n = 16;
                end
                3: begin
                    case ($urandom_range(0, 2))
                        0: p = 34;
                        1: p = 37;
                        default: p = 30;
                    endcase
                    n = 15;
                end
                4: begin p = 35; n = 16; end
                5: begin p = 62; n = $urandom_range(16, 19); end
                6: begin
                    case ($urandom_range(0, 3))
                        0: p = 30;
                        1: p = 36;
                        2: p = 38;
                        default: p = 39;
                    endcase
                    n = 14;
                end
                default: begin p = $urandom_range(60, 69); n = 16; end
            endcase
            if ($urandom_range(0, 4) == 0) n = $urandom_range(12, 20);
            if (p >= 1000) begin
                digs.push_back(p / 1000);
                digs.push_back((p / 100) % 10);
            end
            digs.push_back((p / 10) % 10);
            digs.push_back(p % 10);
            while (digs.size() < n - 1) digs.push_back($urandom_range(0, 9));
            if ($urandom_range(0, 1)) begin
                // check digit so that the whole number passes
                s = 0;
                for (int i = digs.size() - 1; i >= 0; i--) begin
                    v = digs[i];
                    if ((digs.size() - i) % 2 == 1) v = (2 * v > 9) ? 2 * v - 9 : 2 * v;
                    s += v;
                end
                digs.push_back((10 - s % 10) % 10);
            end else begin
                digs.push_back($urandom_range(0, 9));
            end
            send_digits(digs, 1'b1);
        end else if (kind < 85) begin
            n = $urandom_range(0, 26);
            for (int i = 0; i < n; i++) digs.push_back($urandom_range(0, 9));
            send_digits(digs, 1'b1);
        end else begin
            // arbitrary bytes, sometimes with no end mark so the next entry runs on
            n = $urandom_range(1, 20);
            v = ($urandom_range(0, 7) != 0);
            for (int i = 0; i < n; i++)
                send_char(8'($urandom_range(0, 255)), v && i == n - 1);
        end
    endtask

    task automatic run_random_entries(input int target);
        while (chars_sent < target) begin
            if (!quiet) calm = ($urandom_range(0, 5) == 0);
            send_random_entry();
        end
        calm = 1'b0;
    endtask

    task automatic test_empty_entries();
        send_char(CHAR_SPACE, 1'b1);
        send_char(CHAR_DASH, 1'b1);
    endtask

    task automatic test_bad_bytes();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CHAR_NINE + 8'd1, 1'b1);
    endtask

    // 21 digits, no end mark until the last, count must stop at the cap
    task automatic test_digit_saturation();
        for (int i = 0; i < 21; i++)
            send_char(i % 2 ? CHAR_NINE : CHAR_ZERO, i == 20);
    endtask

    // result side held off while short entries keep coming, so the input stalls
    task automatic test_output_hold();
        hold_pending = 1'b1;
        for (int i = 0; i < 40; i++)
            send_char($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // one random entry, then the sender goes quiet until every queued result has been taken
    task automatic test_drain_pause();
        send_random_entry();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_entries();
        test_bad_bytes();
        test_digit_saturation();
        run_random_entries(700);
        test_output_hold();
        test_drain_pause();
        run_random_entries(1400);
        test_drain_pause();
        quiet = 1'b1;
        run_random_entries(1550);
        // close any entry left open by a noise run
        send_char(CHAR_SPACE, 1'b1);

        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d characters in %0d entries, checked %0d results, %0d mismatches",
                 chars_sent, entries_closed, results_checked, mismatches);
        $display("classes seen: unk %0d v %0d m %0d a %0d j %0d u %0d dc %0d ds %0d",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3],
                 class_hits[4], class_hits[5], class_hits[6], class_hits[7]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== card_number_luhn_checker.f =====
rtl/cnlc_pkg.sv
rtl/card_number_luhn_checker.sv
rtl/cnlc_checker.sv
sim/tb_top.sv
